// ----- hdl/chunked_request_splitter_unit_defines.svh -----
// Assertion macros shared by the checker of the chunked request splitter.
`ifndef CHUNKED_REQUEST_SPLITTER_UNIT_DEFINES_SVH
`define CHUNKED_REQUEST_SPLITTER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("%s failed", "label");

// The consequent must hold in the cycle after the antecedent.
`define CRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("%s failed", "label");

`endif

// ----- hdl/crs_pkg.sv -----
// Package with the shared types and constants of the chunked request splitter.
`timescale 1ns / 1ps
package crs_pkg;

  localparam int unsigned OffW = 64;
  localparam int unsigned IdxW = 63;
  localparam int unsigned LenW = 32;
  localparam int unsigned DivSteps = 63;
  localparam int unsigned DivCntW = 6;

  localparam logic [LenW-1:0] ChunkSizeReset = 32'd65536;
  localparam logic [1:0] AccReadOnly = 2'd0;
  localparam logic [1:0] AccWriteOnly = 2'd1;

  typedef enum logic [2:0] {
    ST_PIECE         = 3'd0,
    ST_BAD_HANDLE    = 3'd1,
    ST_NEG_OFFSET    = 3'd2,
    ST_NOT_PERMITTED = 3'd3,
    ST_ZERO_LENGTH   = 3'd4,
    ST_TOO_MANY      = 3'd5
  } status_e;

  typedef struct packed {
    logic                   command;
    logic                   handle_open;
    logic [1:0]             access_mode;
    logic [63:0]            file_id;
    logic signed [OffW-1:0] request_offset;
    logic [LenW-1:0]        request_length;
  } req_t;

  typedef struct packed {
    status_e         status;
    logic            piece_write;
    logic [63:0]     piece_file;
    logic [IdxW-1:0] chunk_index;
    logic [LenW-1:0] chunk_offset;
    logic [LenW-1:0] piece_length;
    logic            last;
  } res_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic check;
    logic emit_piece;
    logic emit_err;
  } cmd_t;

  typedef struct packed {
    logic req_bad;
    logic div_last;
    logic too_many;
    logic piece_last;
  } stat_t;

endpackage

// ----- hdl/crs_datapath.sv -----
// Datapath: request checks, iterative offset divider and piece generator.
`timescale 1ns / 1ps
module crs_datapath #(
  parameter int unsigned MAX_PIECES = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [31:0]   cfg_wdata_i,
  input  crs_pkg::req_t req_i,
  input  crs_pkg::cmd_t cmd_i,
  output crs_pkg::stat_t stat_o,
  output crs_pkg::res_t res_o
);
  import crs_pkg::*;

  localparam int unsigned LimW = LenW + $clog2(MAX_PIECES + 1);
  localparam logic [DivCntW-1:0] DivLast = DivCntW'(DivSteps - 1);

  logic [LenW-1:0]    cs_q;
  logic [LenW-1:0]    cs_eff;
  logic [LimW-1:0]    lim_q;
  status_e            code_d, code_q;
  logic               wr_q;
  logic [63:0]        file_q;
  logic [IdxW-1:0]    quo_q;
  logic [LenW-1:0]    rem_q;
  logic [LenW-1:0]    len_q;
  logic [DivCntW-1:0] cnt_q;
  logic [LenW:0]      trial;
  logic               trial_ge;
  logic [LenW-1:0]    room;
  logic               fits;
  logic [LenW-1:0]    plen;
  logic [LimW-1:0]    span;

  assign cs_eff = (cs_q == '0) ? LenW'(1) : cs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cs_q <= ChunkSizeReset;
    end else if (cfg_we_i) begin
      cs_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lim_q <= LimW'(cs_eff) * LimW'(MAX_PIECES);
  end

  always_comb begin
    if (!req_i.handle_open) begin
      code_d = ST_BAD_HANDLE;
    end else if (req_i.request_offset[OffW-1]) begin
      code_d = ST_NEG_OFFSET;
    end else if ((req_i.command && req_i.access_mode == AccReadOnly) ||
                 (!req_i.command && req_i.access_mode == AccWriteOnly)) begin
      code_d = ST_NOT_PERMITTED;
    end else if (req_i.request_length == '0) begin
      code_d = ST_ZERO_LENGTH;
    end else begin
      code_d = ST_PIECE;
    end
  end

  assign trial    = {rem_q, quo_q[IdxW-1]};
  assign trial_ge = trial >= {1'b0, cs_eff};
  assign room     = cs_eff - rem_q;
  assign fits     = len_q <= room;
  assign plen     = fits ? len_q : room;
  assign span     = LimW'(rem_q) + LimW'(len_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + DivCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      code_q <= code_d;
      wr_q   <= req_i.command;
      file_q <= req_i.file_id;
      quo_q  <= req_i.request_offset[IdxW-1:0];
      rem_q  <= '0;
      len_q  <= req_i.request_length;
    end else if (cmd_i.div_step) begin
      rem_q <= trial_ge ? LenW'(trial - {1'b0, cs_eff}) : trial[LenW-1:0];
      quo_q <= {quo_q[IdxW-2:0], trial_ge};
    end else if (cmd_i.check) begin
      if (span > lim_q) begin
        code_q <= ST_TOO_MANY;
      end
    end else if (cmd_i.emit_piece) begin
      len_q <= len_q - plen;
      rem_q <= '0;
      quo_q <= quo_q + IdxW'(1);
    end
  end

  assign stat_o.req_bad    = (code_d != ST_PIECE);
  assign stat_o.div_last   = (cnt_q == DivLast);
  assign stat_o.too_many   = (span > lim_q);
  assign stat_o.piece_last = fits;

  always_comb begin
    res_o.piece_write = wr_q;
    res_o.piece_file  = file_q;
    if (cmd_i.emit_err) begin
      res_o.status       = code_q;
      res_o.chunk_index  = '0;
      res_o.chunk_offset = '0;
      res_o.piece_length = '0;
      res_o.last         = 1'b1;
    end else begin
      res_o.status       = ST_PIECE;
      res_o.chunk_index  = quo_q;
      res_o.chunk_offset = rem_q;
      res_o.piece_length = plen;
      res_o.last         = fits;
    end
  end

endmodule

// ----- hdl/crs_controller.sv -----
// Controller state machine that sequences load, divide, check and emit.
`timescale 1ns / 1ps
module crs_controller (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  crs_pkg::stat_t stat_i,
  output crs_pkg::cmd_t  cmd_o,
  output logic           strobe_o
);
  import crs_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV   = 5'b00010,
    S_CHECK = 5'b00100,
    S_EMIT  = 5'b01000,
    S_ERR   = 5'b10000
  } state_e;

  state_e state_d, state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = stat_i.req_bad ? S_ERR : S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = stat_i.too_many ? S_ERR : S_EMIT;
      end
      S_EMIT: begin
        cmd_o.emit_piece = 1'b1;
        if (stat_i.piece_last) begin
          state_d = S_IDLE;
        end
      end
      S_ERR: begin
        cmd_o.emit_err = 1'b1;
        state_d        = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy     = (state_q != S_IDLE);
  assign strobe_o = (state_q == S_EMIT) || (state_q == S_ERR);

endmodule

// ----- hdl/chunked_request_splitter_unit.sv -----
// Top level of the chunked request splitter: controller plus datapath.
//
//   Channel   Ports                          Transaction when
//   request   start, busy, req_i             start high and busy low
//   result    strobe_o, res_o                strobe_o high (no stall)
//   config    cfg_we_i, cfg_wdata_i          cfg_we_i high
//
// A request takes a load step, the bit-serial offset divider, a check step and then
// yields one piece per cycle. A request rejected by the handle, offset, access or
// length checks goes from its load step straight to its error result. Reset
// clears the controller and sets the chunk size to 65536. Results are presented
// for one cycle each and are never held back.
`timescale 1ns / 1ps
module chunked_request_splitter_unit #(
  parameter int unsigned MAX_PIECES = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  crs_pkg::req_t req_i,
  output logic          strobe_o,
  output crs_pkg::res_t res_o,
  input  logic          cfg_we_i,
  input  logic [31:0]   cfg_wdata_i
);
  import crs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  crs_controller u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .strobe_o (strobe_o)
  );

  crs_datapath #(
    .MAX_PIECES (MAX_PIECES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .res_o       (res_o)
  );

endmodule

// ----- hdl/crs_checker.sv -----
// Port-level checker for the chunked request splitter and its bind statement.
`timescale 1ns / 1ps
`include "chunked_request_splitter_unit_defines.svh"
module crs_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          strobe_o,
  input crs_pkg::res_t res_o
);
  import crs_pkg::*;

  `CRS_ASSERT_SAME(a_strobe_busy, clk_i, rst_ni, strobe_o, busy)
  `CRS_ASSERT_NEXT(a_last_frees, clk_i, rst_ni, strobe_o && res_o.last, !busy)
  `CRS_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  `CRS_ASSERT_NEXT(a_pieces_run, clk_i, rst_ni, strobe_o && !res_o.last, strobe_o)
  `CRS_ASSERT_SAME(a_status_last, clk_i, rst_ni, strobe_o && res_o.status != ST_PIECE, res_o.last)

endmodule

bind chunked_request_splitter_unit crs_checker u_crs_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .strobe_o (strobe_o),
  .res_o    (res_o)
);

// ----- tb/tb.sv -----
// Self-checking testbench for the chunked request splitter unit.
`timescale 1ns / 1ps
module tb;
  import crs_pkg::*;

  localparam logic [1:0] AccReadWrite = 2'd2;
  localparam logic [1:0] AccUnused = 2'd3;
  localparam logic [63:0] Mask63 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int unsigned MaxPieces = 64;
  localparam int unsigned TailCycles = 150;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  req_t        req_i;
  logic        strobe_o;
  res_t        res_o;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;

  logic [31:0] chunk_size_q;
  res_t        expected_pieces[$];
  int unsigned error_count;

  chunked_request_splitter_unit #(
    .MAX_PIECES(MaxPieces)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .strobe_o   (strobe_o),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch in %s: got %h, want %h", what, got, want);
    error_count++;
  endtask

  function automatic res_t status_result(req_t r, status_e code);
    res_t s;
    s = '0;
    s.status = code;
    s.piece_write = r.command;
    s.piece_file = r.file_id;
    s.last = 1'b1;
    return s;
  endfunction

  task automatic split_request(req_t r);
    logic [63:0] cs;
    logic [63:0] off;
    logic [63:0] len;
    logic [63:0] idx;
    logic [63:0] local_off;
    logic [63:0] npieces;
    logic [63:0] done;
    logic [63:0] plen;
    res_t        p;
    off = r.request_offset;
    len = {32'd0, r.request_length};
    cs = (chunk_size_q == 32'd0) ? 64'd1 : {32'd0, chunk_size_q};
    if (!r.handle_open) begin
      expected_pieces.push_back(status_result(r, ST_BAD_HANDLE));
    end else if (off[63]) begin
      expected_pieces.push_back(status_result(r, ST_NEG_OFFSET));
    end else if ((r.command && r.access_mode == AccReadOnly) ||
                 (!r.command && r.access_mode == AccWriteOnly)) begin
      expected_pieces.push_back(status_result(r, ST_NOT_PERMITTED));
    end else if (len == 64'd0) begin
      expected_pieces.push_back(status_result(r, ST_ZERO_LENGTH));
    end else begin
      idx = off / cs;
      local_off = off % cs;
      npieces = (local_off + len + cs - 64'd1) / cs;
      if (npieces > MaxPieces) begin
        expected_pieces.push_back(status_result(r, ST_TOO_MANY));
      end else begin
        done = 64'd0;
        for (logic [63:0] i = 0; i < npieces; i++) begin
          plen = cs - local_off;
          if (plen > len - done) plen = len - done;
          p = '0;
          p.status = ST_PIECE;
          p.piece_write = r.command;
          p.piece_file = r.file_id;
          p.chunk_index = IdxW'(idx + i);
          p.chunk_offset = LenW'(local_off);
          p.piece_length = LenW'(plen);
          p.last = (i + 64'd1 == npieces);
          expected_pieces.push_back(p);
          done += plen;
          local_off = 64'd0;
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && strobe_o) begin
      if (expected_pieces.size() == 0) begin
        report_mismatch("unexpected result", 64'(res_o.chunk_index), 64'd0);
      end else begin
        want = expected_pieces.pop_front();
        if (res_o.status !== want.status)
          report_mismatch("status", 64'(res_o.status), 64'(want.status));
        if (res_o.piece_write !== want.piece_write)
          report_mismatch("piece_write", 64'(res_o.piece_write), 64'(want.piece_write));
        if (res_o.piece_file !== want.piece_file)
          report_mismatch("piece_file", res_o.piece_file, want.piece_file);
        if (res_o.chunk_index !== want.chunk_index)
          report_mismatch("chunk_index", 64'(res_o.chunk_index), 64'(want.chunk_index));
        if (res_o.chunk_offset !== want.chunk_offset)
          report_mismatch("chunk_offset", 64'(res_o.chunk_offset), 64'(want.chunk_offset));
        if (res_o.piece_length !== want.piece_length)
          report_mismatch("piece_length", 64'(res_o.piece_length), 64'(want.piece_length));
        if (res_o.last !== want.last)
          report_mismatch("last", 64'(res_o.last), 64'(want.last));
      end
    end
  end

  task automatic send_request(req_t r, int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    split_request(r);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_pieces.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_chunk_size(logic [31:0] value);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    chunk_size_q = value;
  endtask

  function automatic req_t make_req(logic cmd, logic hopen, logic [1:0] acc,
                                    logic [63:0] file, logic [63:0] off, logic [31:0] len);
    req_t r;
    r.command = cmd;
    r.handle_open = hopen;
    r.access_mode = acc;
    r.file_id = file;
    r.request_offset = off;
    r.request_length = len;
    return r;
  endfunction

  function automatic req_t random_request(bit well_formed);
    req_t        r;
    logic [63:0] cs;
    logic [63:0] span;
    int unsigned pick;
    r.file_id = {$urandom, $urandom};
    r.command = 1'($urandom_range(0, 1));
    if (well_formed) begin
      r.handle_open = 1'b1;
      pick = $urandom_range(0, 2);
      if (r.command) begin
        r.access_mode = (pick == 0) ? AccWriteOnly : (pick == 1) ? AccReadWrite : AccUnused;
      end else begin
        r.access_mode = (pick == 0) ? AccReadOnly : (pick == 1) ? AccReadWrite : AccUnused;
      end
      r.request_offset = ({$urandom, $urandom} & Mask63) >> $urandom_range(0, 62);
      cs = (chunk_size_q == 32'd0) ? 64'd1 : {32'd0, chunk_size_q};
      span = cs * $urandom_range(1, MaxPieces);
      if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
      r.request_length = 32'(({32'd0, $urandom} % span) + 64'd1);
    end else begin
      r.handle_open = 1'($urandom_range(0, 1));
      r.access_mode = 2'($urandom_range(0, 3));
      r.request_offset = {$urandom, $urandom};
      r.request_length = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
    end
    return r;
  endfunction

  task automatic test_default_chunk_size();
    send_request(make_req(1'b0, 1'b1, AccReadWrite, 64'h1, 64'd0, 32'd1), 0);
    send_request(make_req(1'b1, 1'b1, AccWriteOnly, 64'h2, 64'd65535, 32'd2), 1);
    send_request(make_req(1'b0, 1'b1, AccUnused, 64'h3, 64'd100000, 32'd196608), 0);
    send_request(make_req(1'b1, 1'b1, AccUnused, 64'h4, 64'd0, 32'd4194304), 2);
    send_request(make_req(1'b1, 1'b1, AccReadWrite, 64'h5, 64'd0, 32'd4194305), 0);
    send_request(make_req(1'b0, 1'b1, AccReadOnly, 64'h6, 64'd65536, 32'd65536), 0);
    wait_idle();
  endtask

  task automatic test_rejections();
    send_request(make_req(1'b1, 1'b0, AccReadOnly, 64'hA, 64'h8000_0000_0000_0000, 32'd0), 0);
    send_request(make_req(1'b1, 1'b1, AccReadOnly, 64'hB, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0), 0);
    send_request(make_req(1'b1, 1'b1, AccReadOnly, 64'hC, 64'd10, 32'd0), 3);
    send_request(make_req(1'b0, 1'b1, AccWriteOnly, 64'hD, 64'd10, 32'd5), 0);
    send_request(make_req(1'b0, 1'b1, AccReadWrite, 64'hE, 64'd10, 32'd0), 0);
    wait_idle();
  endtask

  task automatic test_zero_chunk_size();
    set_chunk_size(32'd0);
    send_request(make_req(1'b0, 1'b1, AccReadOnly, 64'hF, 64'd5, 32'd3), 0);
    wait_idle();
  endtask

  task automatic test_chunk_index_wrap();
    set_chunk_size(32'd1);
    send_request(make_req(1'b1, 1'b1, AccWriteOnly, 64'h10, Mask63, 32'd3), 0);
    send_request(make_req(1'b0, 1'b1, AccUnused, 64'h11, 64'd0, 32'd65), 0);
    wait_idle();
  endtask

  task automatic test_widest_chunk();
    set_chunk_size(32'hFFFF_FFFF);
    send_request(make_req(1'b1, 1'b1, AccReadWrite, 64'hFFFF_FFFF_FFFF_FFFF, Mask63,
                          32'hFFFF_FFFF), 0);
    send_request(make_req(1'b0, 1'b1, AccReadWrite, 64'd0, 64'd0, 32'hFFFF_FFFF), 1);
    send_request(make_req(1'b0, 1'b1, AccReadOnly, 64'h12, 64'hFFFF_FFFE, 32'd2), 0);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    logic [31:0] sizes[5];
    bit          burst;
    int unsigned gap;
    sizes[0] = $urandom_range(2, 16);
    sizes[1] = $urandom_range(17, 5000);
    sizes[2] = 32'd1;
    sizes[3] = $urandom;
    sizes[4] = 32'hFFFF_FFFF;
    burst = 1'b0;
    foreach (sizes[s]) begin
      set_chunk_size(sizes[s]);
      for (int n = 0; n < 50; n++) begin
        if (n % 10 == 0) burst = ($urandom_range(0, 2) == 0);
        gap = burst ? 0 : $urandom_range(0, 5);
        send_request(random_request($urandom_range(0, 4) != 0), gap);
      end
      wait_idle();
    end
  endtask

  initial begin
    error_count = 0;
    chunk_size_q = ChunkSizeReset;
    rst_ni <= 1'b0;
    start <= 1'b0;
    req_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_chunk_size();
    test_rejections();
    test_zero_chunk_size();
    test_chunk_index_wrap();
    test_widest_chunk();
    test_random_traffic();
    start <= 1'b0;
    while (expected_pieces.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (error_count == 0 && expected_pieces.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
